[design/pcs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pcs_pkg;

	// Fixed geometry and ambient constants
	localparam logic [31:0] A_CAP   = 32'd82354966;    // piston area, mm^2 Q16.16
	localparam logic [31:0] A_ROD   = 32'd61766225;    // ring area, mm^2 Q16.16
	localparam logic [31:0] P_AMB   = 32'd27199223;    // ambient, MPa Q4.28
	localparam logic [47:0] V_DEAD  = 48'd655360000;   // dead volume, mm^3 Q32.16
	localparam logic [47:0] VOL_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [63:0] PAMB_PROD = 64'(P_AMB) * 64'(A_CAP - A_ROD);
	localparam logic [31:0] PAMB_F  = 32'(PAMB_PROD >> 28);

	// Widths of the shared multiply-accumulate path
	localparam int MUL_AW = 52;
	localparam int ACC_W  = 88;
	localparam int DF_W   = 52;

	localparam logic signed [39:0] S40_MAX = 40'sh7F_FFFF_FFFF;
	localparam logic signed [39:0] S40_MIN = 40'sh80_0000_0000;
	localparam logic [ACC_W-1:0]   ACC_LIMIT = ACC_W'(56'h7F_FFFF_FFFF_FFFF);

	// Register reset values
	localparam logic [1:0]  MODE_RST   = 2'd0;
	localparam logic [31:0] SUPPLY_RST = 32'd161061274;
	localparam logic [31:0] FS_RST     = 32'd6553600;
	localparam logic [31:0] FD_RST     = 32'd1310720;
	localparam logic [31:0] SPRING_RST = 32'd157286;
	localparam logic [25:0] STROKE_RST = 26'd16384000;
	localparam logic [31:0] INVM_RST   = 32'd109227;
	localparam logic [31:0] TSTEP_RST  = 32'd42949673;
	localparam logic [63:0] VROD_PROD  = 64'(STROKE_RST) * 64'(A_ROD);
	localparam logic [47:0] VROD_RST   = V_DEAD + 48'(VROD_PROD >> 16);

	// Register indexes
	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_SUPPLY = 3'd1;
	localparam logic [2:0] REG_FS     = 3'd2;
	localparam logic [2:0] REG_FD     = 3'd3;
	localparam logic [2:0] REG_SPRING = 3'd4;
	localparam logic [2:0] REG_STROKE = 3'd5;
	localparam logic [2:0] REG_INVM   = 3'd6;
	localparam logic [2:0] REG_TSTEP  = 3'd7;

	// Model modes
	localparam logic [1:0] MODE_SEALED = 2'd0;
	localparam logic [1:0] MODE_FIXED  = 2'd1;
	localparam logic [1:0] MODE_SPRING = 2'd2;
	localparam logic [1:0] MODE_HOLD   = 2'd3;

	// Sequencer steps, also the datapath operation codes
	localparam logic [5:0] ST_IDLE = 6'd0;
	localparam logic [5:0] ST_RI0  = 6'd1;
	localparam logic [5:0] ST_RI1  = 6'd2;
	localparam logic [5:0] ST_RI2  = 6'd3;
	localparam logic [5:0] ST_FIX  = 6'd4;
	localparam logic [5:0] ST_NRM  = 6'd5;
	localparam logic [5:0] ST_PV0  = 6'd6;
	localparam logic [5:0] ST_PV1  = 6'd7;
	localparam logic [5:0] ST_DST  = 6'd8;
	localparam logic [5:0] ST_DWT  = 6'd9;
	localparam logic [5:0] ST_VSH  = 6'd10;
	localparam logic [5:0] ST_F0   = 6'd11;
	localparam logic [5:0] ST_F1   = 6'd12;
	localparam logic [5:0] ST_F2   = 6'd13;
	localparam logic [5:0] ST_F3   = 6'd14;
	localparam logic [5:0] ST_F4   = 6'd15;
	localparam logic [5:0] ST_SP0  = 6'd16;
	localparam logic [5:0] ST_SP1  = 6'd17;
	localparam logic [5:0] ST_SP2  = 6'd18;
	localparam logic [5:0] ST_X0   = 6'd19;
	localparam logic [5:0] ST_X1   = 6'd20;
	localparam logic [5:0] ST_X2   = 6'd21;
	localparam logic [5:0] ST_V0   = 6'd22;
	localparam logic [5:0] ST_V1   = 6'd23;
	localparam logic [5:0] ST_V2   = 6'd24;
	localparam logic [5:0] ST_DEC  = 6'd25;
	localparam logic [5:0] ST_A0   = 6'd26;
	localparam logic [5:0] ST_A1   = 6'd27;
	localparam logic [5:0] ST_A2   = 6'd28;
	localparam logic [5:0] ST_VC0  = 6'd29;
	localparam logic [5:0] ST_VC1  = 6'd30;
	localparam logic [5:0] ST_VC2  = 6'd31;
	localparam logic [5:0] ST_VR0  = 6'd32;
	localparam logic [5:0] ST_VR1  = 6'd33;
	localparam logic [5:0] ST_VR2  = 6'd34;
	localparam logic [5:0] ST_OUT  = 6'd35;

	// Accumulator update kinds
	localparam logic [1:0] MAC_NONE = 2'd0;
	localparam logic [1:0] MAC_SET  = 2'd1;
	localparam logic [1:0] MAC_ADD  = 2'd2;
	localparam logic [1:0] MAC_SHA  = 2'd3;

	typedef struct packed {
		logic [5:0] op;
		logic       side;   // 0 cap chamber, 1 rod chamber
		logic       take;   // request accepted this cycle
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       need_acc;
		logic       div_done;
		logic       out_free;
	} sts_t;

endpackage
`default_nettype wire

[design/pneumatic_cylinder_sim_step_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Pneumatic cylinder step engine: one explicit-Euler time step per request.
// Request channel (req_valid/req_ready) carries the restart flag; response
// channel (rsp_valid/rsp_ready) returns cap and rod pressures (Q4.28) and
// the piston position (Q16.16). The user must write registers through cfg_we,
// cfg_index and cfg_data only while no request is in flight; the engine
// does not enforce this. The fixed-pressure modes load supply and ambient
// pressure directly; the friction check may recompute the acceleration, and
// spring mode adds the spring force. Sealed mode swaps the pressure load for
// two divisions (the restoring divider runs 32 iterations), each of which
// ends at once on a zero or overflowing divisor; mode three goes straight to
// the output step. Products go through one shared 52x16 multiplier, chunk by
// chunk. One request is processed at a time; the next can be accepted in the
// same cycle that rsp_valid rises.
// Reset loads the default registers and the initial conditions (supply
// pressure in the cap chamber, ambient in the rod chamber, piston at rest
// at zero). A stalled receiver holds the response; the engine then waits in
// its final step until the output register frees up.
module pneumatic_cylinder_sim_step_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         req_valid,
	output logic              req_ready,
	input  wire logic         restart,
	output logic              rsp_valid,
	input  wire logic         rsp_ready,
	output logic [31:0]       pressure_cap_side,
	output logic [31:0]       pressure_rod_side,
	output logic signed [31:0] position,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import pcs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pcs_dpath u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.restart           (restart),
		.cmd               (cmd),
		.sts               (sts),
		.rsp_ready         (rsp_ready),
		.rsp_valid         (rsp_valid),
		.pressure_cap_side (pressure_cap_side),
		.pressure_rod_side (pressure_rod_side),
		.position          (position)
	);

endmodule
`default_nettype wire

[design/pcs_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module pcs_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      quot
);
	import pcs_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] dq_q;
	logic [31:0] dvs_q;
	logic [32:0] rem2;
	logic        ge;

	// One quotient bit per cycle
	assign rem2 = {rem_q, dq_q[31]};
	assign ge   = rem2 >= {1'b0, dvs_q};

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (divisor == '0 || dividend[63:32] >= divisor) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 6'd32;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift remainder and quotient, saturate on overflow or zero divisor (zero over zero gives zero)
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= dividend[63:32];
			if (divisor == '0) begin
				dq_q <= (dividend != '0) ? '1 : '0;
			end else if (dividend[63:32] >= divisor) begin
				dq_q <= '1;
			end else begin
				dq_q <= dividend[31:0];
			end
		end else if (busy_q) begin
			rem_q <= ge ? 32'(rem2 - {1'b0, dvs_q}) : rem2[31:0];
			dq_q  <= {dq_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign quot = dq_q;

endmodule
`default_nettype wire

[design/pcs_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
module pcs_dpath (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	input  wire logic         restart,
	input  wire pcs_pkg::cmd_t cmd,
	output pcs_pkg::sts_t     sts,
	input  wire logic         rsp_ready,
	output logic              rsp_valid,
	output logic [31:0]       pressure_cap_side,
	output logic [31:0]       pressure_rod_side,
	output logic signed [31:0] position
);
	import pcs_pkg::*;

	// Configuration
	logic [1:0]  mode_q;
	logic [31:0] supply_q, fs_q, fd_q, spring_q, invm_q, tstep_q;
	logic [25:0] stroke_q;

	// Simulation state
	logic [31:0]        pcap_q, prod_q;
	logic [47:0]        vco_q, vcn_q, vro_q, vrn_q;
	logic signed [31:0] pos_q;
	logic signed [39:0] vel_q, accel_q;
	logic               rsp_valid_q;

	// Working registers
	logic                    rst_q;
	logic [47:0]             rinit_q;
	logic [31:0]             vo_q, vn_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [DF_W-1:0]  df_q;
	logic signed [31:0]      x_q;
	logic signed [39:0]      v_q, a_q;
	logic [DF_W-1:0]         fmag_q;
	logic                    fneg_q;
	logic [31:0]             rsp_pc_q, rsp_pr_q;
	logic signed [31:0]      rsp_pos_q;

	// Multiplier and accumulator
	logic [MUL_AW-1:0]       mul_a;
	logic [15:0]             mul_b;
	logic [MUL_AW+15:0]      term;
	logic signed [ACC_W-1:0] term_x, acc_nxt;
	logic [1:0]              mac_op;
	logic                    mac_neg;
	logic signed [ACC_W-1:0] acc_sh16;

	logic [31:0] pos_mag, x_mag, psel;
	logic [39:0] vel_mag, acc_mag;
	logic [47:0] rinit_d;

	// Normalization
	logic [47:0] nvo, nvn, nor_w;
	logic [4:0]  nsh;
	logic [47:0] nvo_s, nvn_s;

	// Integration and decision
	logic [41:0]            tr;
	logic signed [43:0]     xsum, vsum;
	logic signed [DF_W-1:0] fxs, fminus, fplus, fsel;
	logic                   v_zero, dec_need;
	logic signed [32:0]     strk;
	logic [39:0]            ar;
	logic signed [ACC_W-1:0] vct, vrt;
	logic [47:0]            vct_s, vrt_s;

	logic        out_free;
	logic        div_start, div_done;
	logic [31:0] div_q;

	assign pos_mag = pos_q[31] ? 32'(-pos_q) : 32'(pos_q);
	assign x_mag   = x_q[31] ? 32'(-x_q) : 32'(x_q);
	assign vel_mag = vel_q[39] ? 40'(-vel_q) : 40'(vel_q);
	assign acc_mag = accel_q[39] ? 40'(-accel_q) : 40'(accel_q);
	assign psel    = cmd.side ? prod_q : pcap_q;
	assign acc_sh16 = acc_q >>> 16;
	assign rinit_d = V_DEAD + 48'(acc_sh16);

	// Select operands for the shared multiplier
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mac_op  = MAC_NONE;
		mac_neg = 1'b0;
		case (cmd.op)
			ST_RI0: begin mul_a = MUL_AW'(stroke_q); mul_b = A_ROD[15:0];  mac_op = MAC_SET; end
			ST_RI1: begin mul_a = MUL_AW'(stroke_q); mul_b = A_ROD[31:16]; mac_op = MAC_ADD; end
			ST_PV0: begin mul_a = MUL_AW'(psel); mul_b = vo_q[15:0];  mac_op = MAC_SET; end
			ST_PV1: begin mul_a = MUL_AW'(psel); mul_b = vo_q[31:16]; mac_op = MAC_ADD; end
			ST_F0:  begin mul_a = MUL_AW'(pcap_q); mul_b = A_CAP[15:0];  mac_op = MAC_SET; end
			ST_F1:  begin mul_a = MUL_AW'(pcap_q); mul_b = A_CAP[31:16]; mac_op = MAC_ADD; end
			ST_F2:  begin mul_a = MUL_AW'(prod_q); mul_b = A_ROD[15:0];  mac_op = MAC_SET; end
			ST_F3:  begin mul_a = MUL_AW'(prod_q); mul_b = A_ROD[31:16]; mac_op = MAC_ADD; end
			ST_SP0: begin
				mul_a = MUL_AW'(spring_q); mul_b = pos_mag[15:0];
				mac_op = MAC_SET; mac_neg = pos_q[31];
			end
			ST_SP1: begin
				mul_a = MUL_AW'(spring_q); mul_b = pos_mag[31:16];
				mac_op = MAC_ADD; mac_neg = pos_q[31];
			end
			ST_X0:  begin mul_a = MUL_AW'(vel_mag); mul_b = tstep_q[15:0];  mac_op = MAC_SET; end
			ST_X1:  begin mul_a = MUL_AW'(vel_mag); mul_b = tstep_q[31:16]; mac_op = MAC_SHA; end
			ST_V0:  begin mul_a = MUL_AW'(acc_mag); mul_b = tstep_q[15:0];  mac_op = MAC_SET; end
			ST_V1:  begin mul_a = MUL_AW'(acc_mag); mul_b = tstep_q[31:16]; mac_op = MAC_SHA; end
			ST_A0:  begin mul_a = fmag_q; mul_b = invm_q[15:0];  mac_op = MAC_SET; end
			ST_A1:  begin mul_a = fmag_q; mul_b = invm_q[31:16]; mac_op = MAC_ADD; end
			ST_VC0: begin
				mul_a = MUL_AW'(x_mag); mul_b = A_CAP[15:0];
				mac_op = MAC_SET; mac_neg = x_q[31];
			end
			ST_VC1: begin
				mul_a = MUL_AW'(x_mag); mul_b = A_CAP[31:16];
				mac_op = MAC_ADD; mac_neg = x_q[31];
			end
			ST_VR0: begin
				mul_a = MUL_AW'(x_mag); mul_b = A_ROD[15:0];
				mac_op = MAC_SET; mac_neg = x_q[31];
			end
			ST_VR1: begin
				mul_a = MUL_AW'(x_mag); mul_b = A_ROD[31:16];
				mac_op = MAC_ADD; mac_neg = x_q[31];
			end
			default: begin end
		endcase
	end

	assign term   = (MUL_AW+16)'(mul_a) * (MUL_AW+16)'(mul_b);
	assign term_x = signed'(ACC_W'(term));

	// Accumulate the partial product
	always_comb begin
		case (mac_op)
			MAC_SET: acc_nxt = mac_neg ? -term_x : term_x;
			MAC_ADD: acc_nxt = mac_neg ? acc_q - (term_x <<< 16) : acc_q + (term_x <<< 16);
			MAC_SHA: acc_nxt = acc_sh16 + term_x;
			default: acc_nxt = acc_q;
		endcase
	end

	// Shift both volumes until they fit 32 bits
	assign nvo   = cmd.side ? vro_q : vco_q;
	assign nvn   = cmd.side ? vrn_q : vcn_q;
	assign nor_w = nvo | nvn;
	always_comb begin
		nsh = '0;
		for (int i = 0; i < 16; i++) begin
			if (nor_w[32+i]) begin
				nsh = 5'(i + 1);
			end
		end
	end
	assign nvo_s = nvo >> nsh;
	assign nvn_s = nvn >> nsh;

	// Position and velocity integration
	assign tr   = 42'(acc_sh16);
	assign xsum = 44'(pos_q) + (vel_q[39] ? -signed'(44'(tr)) : signed'(44'(tr)));
	assign vsum = 44'(vel_q) + (accel_q[39] ? -signed'(44'(tr)) : signed'(44'(tr)));

	// Friction decision
	assign v_zero = (v_q == '0);
	assign fxs    = signed'(DF_W'(v_zero ? fs_q : fd_q));
	assign fminus = df_q - fxs;
	assign fplus  = df_q + fxs;
	assign strk   = signed'(33'(stroke_q));
	always_comb begin
		dec_need = 1'b0;
		fsel     = fminus;
		if (v_zero) begin
			if (fminus > 0) begin
				dec_need = 1'b1;
			end else if (fplus < 0) begin
				dec_need = 1'b1;
				fsel     = fplus;
			end
		end else if (x_q < 0) begin
			dec_need = 1'b0;
		end else if (33'(x_q) > strk) begin
			dec_need = 1'b0;
		end else if (!v_q[39]) begin
			dec_need = 1'b1;
		end else begin
			dec_need = 1'b1;
			fsel     = fplus;
		end
	end

	assign ar = (acc_q > signed'(ACC_LIMIT)) ? 40'(S40_MAX) : 40'(acc_sh16);

	// New volumes, clamped to the unsigned 48-bit range
	assign vct = signed'(ACC_W'(V_DEAD)) + acc_sh16;
	assign vrt = signed'(ACC_W'(rinit_q)) - acc_sh16;
	assign vct_s = (vct < 0) ? '0 : ((vct > signed'(ACC_W'(VOL_MAX))) ? VOL_MAX : 48'(vct));
	assign vrt_s = (vrt < 0) ? '0 : ((vrt > signed'(ACC_W'(VOL_MAX))) ? VOL_MAX : 48'(vrt));

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign div_start = (cmd.op == ST_DST);

	pcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (64'(acc_q)),
		.divisor  (vn_q),
		.done     (div_done),
		.quot     (div_q)
	);

	// Configuration, simulation state and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_RST;
			supply_q    <= SUPPLY_RST;
			fs_q        <= FS_RST;
			fd_q        <= FD_RST;
			spring_q    <= SPRING_RST;
			stroke_q    <= STROKE_RST;
			invm_q      <= INVM_RST;
			tstep_q     <= TSTEP_RST;
			pcap_q      <= SUPPLY_RST;
			prod_q      <= P_AMB;
			vco_q       <= V_DEAD;
			vcn_q       <= V_DEAD;
			vro_q       <= VROD_RST;
			vrn_q       <= VROD_RST;
			pos_q       <= '0;
			vel_q       <= '0;
			accel_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:   mode_q   <= cfg_data[1:0];
					REG_SUPPLY: supply_q <= cfg_data;
					REG_FS:     fs_q     <= cfg_data;
					REG_FD:     fd_q     <= cfg_data;
					REG_SPRING: spring_q <= cfg_data;
					REG_STROKE: stroke_q <= cfg_data[25:0];
					REG_INVM:   invm_q   <= cfg_data;
					REG_TSTEP:  tstep_q  <= cfg_data;
					default: begin end
				endcase
			end
			// Raise on a finished step, drop once the response is taken
			if (cmd.op == ST_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (cmd.op)
				ST_RI2: begin
					if (rst_q) begin
						pcap_q  <= supply_q;
						prod_q  <= P_AMB;
						vco_q   <= V_DEAD;
						vcn_q   <= V_DEAD;
						vro_q   <= rinit_d;
						vrn_q   <= rinit_d;
						pos_q   <= '0;
						vel_q   <= '0;
						accel_q <= '0;
					end
				end
				ST_FIX: begin
					pcap_q <= supply_q;
					prod_q <= P_AMB;
				end
				ST_DWT: begin
					if (div_done) begin
						if (cmd.side) begin
							prod_q <= div_q;
						end else begin
							pcap_q <= div_q;
						end
					end
				end
				ST_VSH: begin
					vco_q <= vcn_q;
					vro_q <= vrn_q;
				end
				ST_VC0: begin
					pos_q   <= x_q;
					vel_q   <= v_q;
					accel_q <= a_q;
				end
				ST_VC2: vcn_q <= vct_s;
				ST_VR2: vrn_q <= vrt_s;
				default: begin end
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		acc_q <= acc_nxt;
		if (cmd.take) begin
			rst_q <= restart;
		end
		case (cmd.op)
			ST_RI2: rinit_q <= rinit_d;
			ST_NRM: begin
				vo_q <= nvo_s[31:0];
				vn_q <= nvn_s[31:0];
			end
			ST_F2: df_q <= DF_W'(acc_q >>> 28);
			ST_F4: df_q <= df_q - DF_W'(acc_q >>> 28) - signed'(DF_W'(PAMB_F));
			ST_SP2: df_q <= df_q - DF_W'(acc_sh16);
			ST_X2: begin
				if (xsum > 44'sh0_7FFF_FFFF) begin
					x_q <= 32'sh7FFF_FFFF;
				end else if (xsum < -44'sh0_8000_0000) begin
					x_q <= 32'sh8000_0000;
				end else begin
					x_q <= 32'(xsum);
				end
			end
			ST_V2: begin
				if (vsum > 44'(S40_MAX)) begin
					v_q <= S40_MAX;
				end else if (vsum < 44'(S40_MIN)) begin
					v_q <= S40_MIN;
				end else begin
					v_q <= 40'(vsum);
				end
			end
			ST_DEC: begin
				a_q    <= v_zero ? '0 : accel_q;
				fmag_q <= fsel[DF_W-1] ? DF_W'(-fsel) : DF_W'(fsel);
				fneg_q <= fsel[DF_W-1];
				if (!v_zero && x_q < 0) begin
					x_q <= '0;
					v_q <= '0;
				end else if (!v_zero && 33'(x_q) > strk) begin
					x_q <= 32'(stroke_q);
					v_q <= '0;
				end
			end
			ST_A2: a_q <= fneg_q ? -signed'(ar) : signed'(ar);
			ST_OUT: begin
				if (out_free) begin
					rsp_pc_q  <= pcap_q;
					rsp_pr_q  <= prod_q;
					rsp_pos_q <= pos_q;
				end
			end
			default: begin end
		endcase
	end

	assign sts.mode     = mode_q;
	assign sts.need_acc = dec_need;
	assign sts.div_done = div_done;
	assign sts.out_free = out_free;

	assign rsp_valid         = rsp_valid_q;
	assign pressure_cap_side = rsp_pc_q;
	assign pressure_rod_side = rsp_pr_q;
	assign position          = rsp_pos_q;

endmodule
`default_nettype wire

[design/pcs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module pcs_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire pcs_pkg::sts_t sts,
	output pcs_pkg::cmd_t      cmd
);
	import pcs_pkg::*;

	logic [5:0] state_q, state_d;
	logic       side_q, side_d;
	logic       take;

	assign req_ready = (state_q == ST_IDLE);
	assign take      = req_valid && req_ready;

	// Next step of the sequence
	always_comb begin
		state_d = state_q;
		side_d  = side_q;
		case (state_q)
			ST_IDLE: if (take) state_d = ST_RI0;
			ST_RI0:  state_d = ST_RI1;
			ST_RI1:  state_d = ST_RI2;
			ST_RI2: begin
				side_d = 1'b0;
				if (sts.mode == MODE_HOLD) begin
					state_d = ST_OUT;
				end else if (sts.mode == MODE_SEALED) begin
					state_d = ST_NRM;
				end else begin
					state_d = ST_FIX;
				end
			end
			ST_FIX:  state_d = ST_VSH;
			ST_NRM:  state_d = ST_PV0;
			ST_PV0:  state_d = ST_PV1;
			ST_PV1:  state_d = ST_DST;
			ST_DST:  state_d = ST_DWT;
			ST_DWT: begin
				if (sts.div_done) begin
					if (side_q) begin
						state_d = ST_VSH;
					end else begin
						side_d  = 1'b1;
						state_d = ST_NRM;
					end
				end
			end
			ST_VSH:  state_d = ST_F0;
			ST_F0:   state_d = ST_F1;
			ST_F1:   state_d = ST_F2;
			ST_F2:   state_d = ST_F3;
			ST_F3:   state_d = ST_F4;
			ST_F4:   state_d = (sts.mode == MODE_SPRING) ? ST_SP0 : ST_X0;
			ST_SP0:  state_d = ST_SP1;
			ST_SP1:  state_d = ST_SP2;
			ST_SP2:  state_d = ST_X0;
			ST_X0:   state_d = ST_X1;
			ST_X1:   state_d = ST_X2;
			ST_X2:   state_d = ST_V0;
			ST_V0:   state_d = ST_V1;
			ST_V1:   state_d = ST_V2;
			ST_V2:   state_d = ST_DEC;
			ST_DEC:  state_d = sts.need_acc ? ST_A0 : ST_VC0;
			ST_A0:   state_d = ST_A1;
			ST_A1:   state_d = ST_A2;
			ST_A2:   state_d = ST_VC0;
			ST_VC0:  state_d = ST_VC1;
			ST_VC1:  state_d = ST_VC2;
			ST_VC2:  state_d = ST_VR0;
			ST_VR0:  state_d = ST_VR1;
			ST_VR1:  state_d = ST_VR2;
			ST_VR2:  state_d = ST_OUT;
			ST_OUT:  if (sts.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold the step and the chamber select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			side_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			side_q  <= side_d;
		end
	end

	assign cmd.op   = state_q;
	assign cmd.side = side_q;
	assign cmd.take = take;

endmodule
`default_nettype wire

[design/pcs_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
module pcs_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [31:0] position
);

	// A stalled response stays
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// A stalled response keeps its position
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(position))
		else $error("response changed while stalled");

	// One request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while busy");

	// Finishing a request always presents its response
	a_done_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(req_ready) |-> rsp_valid)
		else $error("engine went idle without a response");

	// A new response appears only at the end of a step
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("response raised while idle");

endmodule

bind pneumatic_cylinder_sim_step_core pcs_chk u_pcs_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.position  (position)
);
`default_nettype wire
